@@ rtl/m3i_pkg.sv @@
// m3i_pkg: shared types, widths and index tables for the 3x3 matrix inverse.
// No dependencies; every other file of the block imports it.
`default_nettype none

package m3i_pkg;

  // fixed-point format of entries and results
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;           // one entry product
  localparam int DET_W     = PROD_W + DATA_W + 1;  // signed determinant, six terms
  localparam int DMAG_W    = DET_W - 1;            // determinant magnitude
  localparam int QBITS     = DATA_W + 1;           // quotient bits kept before clipping
  localparam int REM_W     = DMAG_W + QBITS;       // division remainder
  localparam int NUM_W     = PROD_W + 2 * FRAC_BITS;
  localparam int N_TRIP    = 6;
  localparam int N_COF     = 9;
  localparam int IDX_W     = 4;

  // Sarrus terms: three entry indexes each, subtract flag per term
  localparam logic [IDX_W-1:0] TRIP_IDX [N_TRIP][3] = '{
    '{4'd0, 4'd4, 4'd8}, '{4'd3, 4'd7, 4'd2}, '{4'd6, 4'd1, 4'd5},
    '{4'd0, 4'd7, 4'd5}, '{4'd3, 4'd1, 4'd8}, '{4'd6, 4'd4, 4'd2}
  };
  localparam logic [N_TRIP-1:0] TRIP_SUB = 6'b111000;

  // cofactors of the transposed matrix: a*b - c*d, sign flip per entry
  localparam logic [IDX_W-1:0] COF_IDX [N_COF][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd1, 4'd8, 4'd2, 4'd7}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd3, 4'd8, 4'd5, 4'd6}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd0, 4'd5, 4'd2, 4'd3},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd0, 4'd7, 4'd1, 4'd6}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };
  localparam logic [N_COF-1:0] COF_FLIP = 9'b010101010;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_r0_c0;
    logic signed [DATA_W-1:0] in_r0_c1;
    logic signed [DATA_W-1:0] in_r0_c2;
    logic signed [DATA_W-1:0] in_r1_c0;
    logic signed [DATA_W-1:0] in_r1_c1;
    logic signed [DATA_W-1:0] in_r1_c2;
    logic signed [DATA_W-1:0] in_r2_c0;
    logic signed [DATA_W-1:0] in_r2_c1;
    logic signed [DATA_W-1:0] in_r2_c2;
  } m3i_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_r0_c0;
    logic signed [DATA_W-1:0] out_r0_c1;
    logic signed [DATA_W-1:0] out_r0_c2;
    logic signed [DATA_W-1:0] out_r1_c0;
    logic signed [DATA_W-1:0] out_r1_c1;
    logic signed [DATA_W-1:0] out_r1_c2;
    logic signed [DATA_W-1:0] out_r2_c0;
    logic signed [DATA_W-1:0] out_r2_c1;
    logic signed [DATA_W-1:0] out_r2_c2;
    logic                     singular;
    logic                     saturated;
  } m3i_out_t;

  // state of one matrix while its nine divisions run
  typedef struct packed {
    logic                              singular;
    logic                              dneg;
    logic [DMAG_W-1:0]                 dmag;
    logic [N_COF-1:0]                  cneg;
    logic [N_COF-1:0]                  ovf;
    logic [N_COF-1:0][REM_W-1:0]       rem;
    logic [N_COF-1:0][QBITS-1:0]       q;
  } m3i_dv_t;

endpackage

`default_nettype wire

@@ rtl/m3i_front.sv @@
// m3i_front: products, determinant and cofactors, seven register stages.
// Depends on m3i_pkg.
`default_nettype none

module m3i_front import m3i_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire m3i_in_t data_i,
  output logic         valid_o,
  output m3i_dv_t      div_o
);

  function automatic logic [DATA_W-1:0] abs_e(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  logic signed [DATA_W-1:0] e [9];
  assign e[0] = data_i.in_r0_c0;
  assign e[1] = data_i.in_r0_c1;
  assign e[2] = data_i.in_r0_c2;
  assign e[3] = data_i.in_r1_c0;
  assign e[4] = data_i.in_r1_c1;
  assign e[5] = data_i.in_r1_c2;
  assign e[6] = data_i.in_r2_c0;
  assign e[7] = data_i.in_r2_c1;
  assign e[8] = data_i.in_r2_c2;

  // stage A: entry-pair products
  logic                     a_v_q;
  logic [PROD_W-1:0]        a_pa_d [N_TRIP], a_pa_q [N_TRIP];
  logic [DATA_W-1:0]        a_mc_d [N_TRIP], a_mc_q [N_TRIP];
  logic [N_TRIP-1:0]        a_sg_d, a_sg_q;
  logic signed [PROD_W-1:0] a_cp_d [N_COF], a_cp_q [N_COF];
  logic signed [PROD_W-1:0] a_cq_d [N_COF], a_cq_q [N_COF];

  always_comb begin
    for (int k = 0; k < N_TRIP; k++) begin
      a_pa_d[k] = abs_e(e[TRIP_IDX[k][0]]) * abs_e(e[TRIP_IDX[k][1]]);
      a_mc_d[k] = abs_e(e[TRIP_IDX[k][2]]);
      a_sg_d[k] = e[TRIP_IDX[k][0]][DATA_W-1] ^ e[TRIP_IDX[k][1]][DATA_W-1] ^
                  e[TRIP_IDX[k][2]][DATA_W-1] ^ TRIP_SUB[k];
    end
    for (int k = 0; k < N_COF; k++) begin
      a_cp_d[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]];
      a_cq_d[k] = e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
    end
  end

  // stage B: third factor as two half products; cofactor difference
  logic                     b_v_q;
  logic [PROD_W-1:0]        b_tlo_d [N_TRIP], b_tlo_q [N_TRIP];
  logic [PROD_W-1:0]        b_thi_d [N_TRIP], b_thi_q [N_TRIP];
  logic [N_TRIP-1:0]        b_sg_q;
  logic [PROD_W-1:0]        b_diff [N_COF];
  logic [PROD_W-1:0]        b_cm_d [N_COF], b_cm_q [N_COF];
  logic [N_COF-1:0]         b_cn_d, b_cn_q;

  always_comb begin
    for (int k = 0; k < N_TRIP; k++) begin
      b_tlo_d[k] = a_pa_q[k][DATA_W-1:0] * a_mc_q[k];
      b_thi_d[k] = a_pa_q[k][PROD_W-1:DATA_W] * a_mc_q[k];
    end
    for (int k = 0; k < N_COF; k++) begin
      // wraps at 64 bits; the top bit is taken as the sign
      b_diff[k] = PROD_W'(a_cp_q[k] - a_cq_q[k]);
      b_cn_d[k] = (b_diff[k][PROD_W-1] ^ COF_FLIP[k]) && (b_diff[k] != '0);
      b_cm_d[k] = b_diff[k][PROD_W-1] ? PROD_W'(-b_diff[k]) : b_diff[k];
    end
  end

  // stage C: signed Sarrus terms
  logic             c_v_q;
  logic [DET_W-1:0] c_tx [N_TRIP];
  logic [DET_W-1:0] c_t_d [N_TRIP], c_t_q [N_TRIP];
  logic [PROD_W-1:0] c_cm_q [N_COF];
  logic [N_COF-1:0]  c_cn_q;

  always_comb begin
    for (int k = 0; k < N_TRIP; k++) begin
      c_tx[k]  = DET_W'({b_thi_q[k], {DATA_W{1'b0}}}) + DET_W'(b_tlo_q[k]);
      c_t_d[k] = b_sg_q[k] ? DET_W'(-c_tx[k]) : c_tx[k];
    end
  end

  // stage D: pairwise sums
  logic             d_v_q;
  logic [DET_W-1:0] d_s_d [3], d_s_q [3];
  logic [PROD_W-1:0] d_cm_q [N_COF];
  logic [N_COF-1:0]  d_cn_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_s_d[k] = c_t_q[2*k] + c_t_q[2*k+1];
    end
  end

  // stage E: determinant
  logic              e_v_q;
  logic [DET_W-1:0]  e_det_d, e_det_q;
  logic [PROD_W-1:0] e_cm_q [N_COF];
  logic [N_COF-1:0]  e_cn_q;

  assign e_det_d = d_s_q[0] + d_s_q[1] + d_s_q[2];

  // stage F: singular check and determinant magnitude
  logic              f_v_q;
  logic              f_sing_q, f_dneg_q;
  logic [DMAG_W-1:0] f_dmag_d, f_dmag_q;
  logic [PROD_W-1:0] f_cm_q [N_COF];
  logic [N_COF-1:0]  f_cn_q;

  assign f_dmag_d = e_det_q[DET_W-1] ? DMAG_W'(-e_det_q) : e_det_q[DMAG_W-1:0];

  // stage G: scaled numerators and quotient range check
  logic              g_v_q;
  m3i_dv_t           g_d, g_q;
  logic [REM_W-1:0]  g_num [N_COF];

  always_comb begin
    g_d          = g_q;
    g_d.singular = f_sing_q;
    g_d.dneg     = f_dneg_q;
    g_d.dmag     = f_dmag_q;
    g_d.cneg     = f_cn_q;
    for (int k = 0; k < N_COF; k++) begin
      g_num[k]    = REM_W'(f_cm_q[k]) << (2 * FRAC_BITS);
      g_d.ovf[k]  = g_num[k] >= (REM_W'(f_dmag_q) << QBITS);
      g_d.rem[k]  = g_num[k];
      g_d.q[k]    = '0;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pa_q   <= a_pa_d;
      a_mc_q   <= a_mc_d;
      a_sg_q   <= a_sg_d;
      a_cp_q   <= a_cp_d;
      a_cq_q   <= a_cq_d;
      b_tlo_q  <= b_tlo_d;
      b_thi_q  <= b_thi_d;
      b_sg_q   <= a_sg_q;
      b_cm_q   <= b_cm_d;
      b_cn_q   <= b_cn_d;
      c_t_q    <= c_t_d;
      c_cm_q   <= b_cm_q;
      c_cn_q   <= b_cn_q;
      d_s_q    <= d_s_d;
      d_cm_q   <= c_cm_q;
      d_cn_q   <= c_cn_q;
      e_det_q  <= e_det_d;
      e_cm_q   <= d_cm_q;
      e_cn_q   <= d_cn_q;
      f_sing_q <= (e_det_q == '0);
      f_dneg_q <= e_det_q[DET_W-1];
      f_dmag_q <= f_dmag_d;
      f_cm_q   <= e_cm_q;
      f_cn_q   <= e_cn_q;
      g_q      <= g_d;
    end
  end

  assign valid_o = g_v_q;
  assign div_o   = g_q;

endmodule

`default_nettype wire

@@ rtl/m3i_div_step.sv @@
// m3i_div_step: one restoring division step for all nine cofactors.
// Depends on m3i_pkg.
`default_nettype none

module m3i_div_step import m3i_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire m3i_dv_t d_i,
  output logic         valid_o,
  output m3i_dv_t      d_o
);

  // remainder runs pre-shifted, so the divisor sits at a fixed position
  logic [REM_W-1:0] dsh;
  logic [REM_W-1:0] rnew [N_COF];
  logic [N_COF-1:0] ge;
  m3i_dv_t          d_d, d_q;
  logic             v_q;

  assign dsh = REM_W'(d_i.dmag) << (QBITS - 1);

  always_comb begin
    d_d = d_i;
    for (int k = 0; k < N_COF; k++) begin
      ge[k]       = d_i.rem[k] >= dsh;
      rnew[k]     = ge[k] ? d_i.rem[k] - dsh : d_i.rem[k];
      d_d.rem[k]  = rnew[k] << 1;
      d_d.q[k]    = {d_i.q[k][QBITS-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign d_o     = d_q;

endmodule

`default_nettype wire

@@ rtl/m3i_round.sv @@
// m3i_round: rounding, sign, saturation and singular override, two stages.
// Depends on m3i_pkg.
`default_nettype none

module m3i_round import m3i_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire m3i_dv_t d_i,
  output logic         valid_o,
  output m3i_out_t     data_o
);

  localparam logic [QBITS:0] LIM_POS = (QBITS+1)'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic [QBITS:0] LIM_NEG = (QBITS+1)'(64'd1 << (DATA_W - 1));

  // stage 1: round half away from zero (remainder is held scaled)
  logic             r_v_q;
  logic [REM_W-1:0] dsh;
  logic [QBITS:0]   r_qr_d [N_COF], r_qr_q [N_COF];
  logic [N_COF-1:0] r_sn_q, r_ovf_q;
  logic             r_sing_q;

  assign dsh = REM_W'(d_i.dmag) << (QBITS - 1);

  always_comb begin
    for (int k = 0; k < N_COF; k++) begin
      r_qr_d[k] = {1'b0, d_i.q[k]} + (QBITS+1)'(d_i.rem[k] >= dsh);
    end
  end

  // stage 2: sign and clip
  logic              o_v_q;
  logic [N_COF-1:0]  neg, sat;
  logic [QBITS:0]    lim [N_COF];
  logic [DATA_W-1:0] mag [N_COF], val [N_COF];
  m3i_out_t          o_d, o_q;

  always_comb begin
    for (int k = 0; k < N_COF; k++) begin
      neg[k] = r_sn_q[k] && (r_ovf_q[k] || (r_qr_q[k] != '0));
      lim[k] = neg[k] ? LIM_NEG : LIM_POS;
      sat[k] = r_ovf_q[k] || (r_qr_q[k] > lim[k]);
      mag[k] = sat[k] ? lim[k][DATA_W-1:0] : r_qr_q[k][DATA_W-1:0];
      val[k] = r_sing_q ? '0 : (neg[k] ? DATA_W'(-mag[k]) : mag[k]);
    end
    o_d.out_r0_c0 = val[0];
    o_d.out_r0_c1 = val[1];
    o_d.out_r0_c2 = val[2];
    o_d.out_r1_c0 = val[3];
    o_d.out_r1_c1 = val[4];
    o_d.out_r1_c2 = val[5];
    o_d.out_r2_c0 = val[6];
    o_d.out_r2_c1 = val[7];
    o_d.out_r2_c2 = val[8];
    o_d.singular  = r_sing_q;
    o_d.saturated = !r_sing_q && (sat != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      r_v_q <= valid_i;
      o_v_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_qr_q   <= r_qr_d;
      r_sn_q   <= d_i.cneg ^ {N_COF{d_i.dneg}};
      r_ovf_q  <= d_i.ovf;
      r_sing_q <= d_i.singular;
      o_q      <= o_d;
    end
  end

  assign valid_o = o_v_q;
  assign data_o  = o_q;

endmodule

`default_nettype wire

@@ rtl/matrix3_inverse.sv @@
// Inverse of a 3x3 signed Q16.16 matrix by the adjugate over the exact determinant.
// One matrix request is taken every cycle while in_stall_o is low; its result passes
// through seven front stages (products, determinant), the 33 one-bit restoring
// division stages, two rounding stages and the output register.
// A singular matrix returns zeros with singular set; clipped entries set saturated.
// Depends on m3i_pkg, m3i_front, m3i_div_step and m3i_round.
`default_nettype none

module matrix3_inverse import m3i_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire m3i_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output m3i_out_t      out_data_o
);

  // pipeline moves while the skid register is free
  logic en;
  logic skid_v_q, out_v_q;
  m3i_out_t skid_q, out_q;

  assign en = !skid_v_q;

  logic    fr_v;
  m3i_dv_t fr_d;

  m3i_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_v),
    .div_o   (fr_d)
  );

  // division chain, one quotient bit per stage
  logic    st_v [QBITS+1];
  m3i_dv_t st_d [QBITS+1];

  assign st_v[0] = fr_v;
  assign st_d[0] = fr_d;

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    m3i_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_v[i]),
      .d_i     (st_d[i]),
      .valid_o (st_v[i+1]),
      .d_o     (st_d[i+1])
    );
  end

  logic     rd_v;
  m3i_out_t rd_d;

  m3i_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_v[QBITS]),
    .d_i     (st_d[QBITS]),
    .valid_o (rd_v),
    .data_o  (rd_d)
  );

  // output register with skid
  logic out_take;
  assign out_take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (rd_v) begin
        if (!out_v_q || out_take) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (out_take) begin
        out_v_q <= 1'b0;
      end
    end else if (out_take) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rd_v) begin
        if (!out_v_q || out_take) begin
          out_q <= rd_d;
        end else begin
          skid_q <= rd_d;
        end
      end
    end else if (out_take) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // skid holds a result only behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid full with empty output register");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without output stall");

  // singular results carry zeros and no saturation
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.singular) |->
      (!out_q.saturated && out_q.out_r0_c0 == '0 && out_q.out_r1_c1 == '0 &&
       out_q.out_r2_c2 == '0))
    else $error("singular result not cleared");

endmodule

`default_nettype wire

@@ dv/matrix3_inverse_tb.sv @@
// Testbench for matrix3_inverse: drives 3x3 Q16.16 matrices and checks each inverse
// against a bit-exact predictor (exact determinant, adjugate, rounded division).
// Depends on m3i_pkg and the matrix3_inverse RTL.
`default_nettype none

module matrix3_inverse_tb;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 43;
  localparam int WD_LIMIT = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  m3i_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  m3i_out_t out_data_o;

  m3i_out_t inverse_q[$];
  int       n_errors = 0;
  int       idle_pct = 6;
  int       quiet_cycles = 0;

  matrix3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // compute the expected inverse of one matrix
  function automatic m3i_out_t predict_inverse(m3i_in_t m);
    logic signed [DATA_W-1:0] e [9];
    logic signed [127:0] det, cof, num, q, r, absd, lim;
    logic signed [127:0] adj [9];
    m3i_out_t res;
    logic [DATA_W-1:0] vals [9];
    logic sat;
    e = '{m.in_r0_c0, m.in_r0_c1, m.in_r0_c2, m.in_r1_c0, m.in_r1_c1,
          m.in_r1_c2, m.in_r2_c0, m.in_r2_c1, m.in_r2_c2};
    det = 128'(e[0]) * e[4] * e[8] + 128'(e[3]) * e[7] * e[2]
        + 128'(e[6]) * e[1] * e[5] - 128'(e[0]) * e[7] * e[5]
        - 128'(e[3]) * e[1] * e[8] - 128'(e[6]) * e[4] * e[2];
    res = '0;
    sat = 1'b0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    adj[0] = 128'(e[4]) * e[8] - 128'(e[5]) * e[7];
    adj[1] = 128'(e[2]) * e[7] - 128'(e[1]) * e[8];
    adj[2] = 128'(e[1]) * e[5] - 128'(e[2]) * e[4];
    adj[3] = 128'(e[5]) * e[6] - 128'(e[3]) * e[8];
    adj[4] = 128'(e[0]) * e[8] - 128'(e[2]) * e[6];
    adj[5] = 128'(e[2]) * e[3] - 128'(e[0]) * e[5];
    adj[6] = 128'(e[3]) * e[7] - 128'(e[4]) * e[6];
    adj[7] = 128'(e[1]) * e[6] - 128'(e[0]) * e[7];
    adj[8] = 128'(e[0]) * e[4] - 128'(e[1]) * e[3];
    absd = det < 0 ? -det : det;
    for (int k = 0; k < 9; k++) begin
      cof = adj[k] < 0 ? -adj[k] : adj[k];
      num = cof <<< (2 * FRAC_BITS);
      q = num / absd;
      r = num % absd;
      // ties go away from zero
      if (2 * r >= absd) q = q + 1;
      if ((adj[k] < 0) != (det < 0) && q != 0) begin
        lim = 128'sh8000_0000;
        if (q > lim) begin q = lim; sat = 1'b1; end
        vals[k] = DATA_W'(-q);
      end else begin
        lim = 128'sh7FFF_FFFF;
        if (q > lim) begin q = lim; sat = 1'b1; end
        vals[k] = DATA_W'(q);
      end
    end
    res.out_r0_c0 = vals[0]; res.out_r0_c1 = vals[1]; res.out_r0_c2 = vals[2];
    res.out_r1_c0 = vals[3]; res.out_r1_c1 = vals[4]; res.out_r1_c2 = vals[5];
    res.out_r2_c0 = vals[6]; res.out_r2_c1 = vals[7]; res.out_r2_c2 = vals[8];
    res.saturated = sat;
    return res;
  endfunction

  // send one matrix request, with random idle cycles ahead of it;
  // valid drops in the idle cycles or when the sender waits for a drain
  task automatic send_matrix(m3i_in_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    inverse_q.push_back(predict_inverse(m));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom();
      1: return DATA_W'($signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
      2: return DATA_W'($signed($urandom_range(511)) - 256);
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return DATA_W'($signed($urandom_range(6) - 3) <<< FRAC_BITS);
      default: return 32'(1 << $urandom_range(31));
    endcase
  endfunction

  function automatic m3i_in_t diag(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                   logic [DATA_W-1:0] c);
    m3i_in_t m;
    m = '0;
    m.in_r0_c0 = a; m.in_r1_c1 = b; m.in_r2_c2 = c;
    return m;
  endfunction

  // corner matrices: identity, singular, saturation, extremes
  task automatic test_directed();
    m3i_in_t m;
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix('0);
    send_matrix({9{32'h0001_0000}});
    send_matrix(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000));
    send_matrix(diag(32'h0003_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0000_0003, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
    m = '0;
    m.in_r0_c2 = 32'h0001_0000; m.in_r1_c1 = 32'h0001_0000; m.in_r2_c0 = 32'hFFFF_0000;
    send_matrix(m);
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
                 32'h000A_0000});
  endtask

  // random matrices, including rank-deficient ones
  task automatic test_random(int count);
    m3i_in_t m;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 9; k++) m[k*DATA_W +: DATA_W] = rand_entry();
      if ($urandom_range(9) == 0) m[0 +: 3*DATA_W] = m[3*DATA_W +: 3*DATA_W];
      send_matrix(m);
    end
  endtask

  // back-to-back with no idling, then a full drain before resuming
  task automatic test_streaming();
    idle_pct = 0;
    test_random(200);
    idle_pct = 6;
    wait_drained();
    test_random(50);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // result check
  always @(posedge clk_i) begin
    m3i_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_res = inverse_q.pop_front();
        if (exp_res !== out_data_o) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_res, out_data_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_streaming();
    test_random(235);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && inverse_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/m3i_pkg.sv
rtl/m3i_front.sv
rtl/m3i_div_step.sv
rtl/m3i_round.sv
rtl/matrix3_inverse.sv
dv/matrix3_inverse_tb.sv
